/* rtl/qxm_pkg.sv */
// Shared types, constants and register layout of the quad X PID mixer.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package qxm_pkg;

    // Fixed-point fraction of angles, rates, set points and errors.
    localparam int RATE_FRAC_BITS = 8;

    localparam int ANGLE_W = 16;
    localparam int RATE_W  = 20;
    localparam int PULSE_W = 12;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 22;
    localparam int SUM_W   = 20;
    localparam int PID_W   = 11;
    localparam int MOT_W   = 14;
    localparam int CFG_W   = 48;
    localparam int ACC_W   = 42;

    // Set point numerator: dead-banded pulse scaled up, minus the level term.
    localparam int DB_W   = 14;
    localparam int NUM_W  = (((DB_W - 1 + RATE_FRAC_BITS) > RATE_W) ?
                             (DB_W - 1 + RATE_FRAC_BITS) : RATE_W) + 1;
    // Divide by three as a multiply by a rounded-up reciprocal.
    localparam int DIV_K  = NUM_W - 1;
    localparam int DIV_RW = DIV_K + 1;
    localparam logic [DIV_K:0] SP_RECIP =
        DIV_RW'(((64'd1 << DIV_RW) + 64'd2) / 64'd3);
    localparam int CALC_W = ((NUM_W > RATE_W) ? NUM_W : RATE_W) + 1;

    localparam int RND_SHIFT = RATE_FRAC_BITS + 8;

    localparam int DEADBAND_HIGH    = 1508;
    localparam int DEADBAND_LOW     = 1492;
    localparam int YAW_ARM_THROTTLE = 1050;
    localparam int LEVEL_GAIN       = 15;
    localparam int ERR_MAX          = 2097151;
    localparam int ERR_MIN          = -2097152;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_KP,
        CFG_KI,
        CFG_KD,
        CFG_PID_LIMIT,
        CFG_INT_LIMIT,
        CFG_THR_IDLE,
        CFG_MOTOR_MIN,
        CFG_MOTOR_MAX
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0]   kp;
        logic [CFG_W-1:0]   ki;
        logic [CFG_W-1:0]   kd;
        logic [9:0]         pid_limit;
        logic [18:0]        integral_limit;
        logic [PULSE_W-1:0] throttle_idle;
        logic [PULSE_W-1:0] motor_min;
        logic [PULSE_W-1:0] motor_max;
    } cfg_t;

    // One classified request passed from front to back.
    typedef struct packed {
        logic signed [ERR_W-1:0] err_yaw;
        logic signed [ERR_W-1:0] err_pitch;
        logic signed [ERR_W-1:0] err_roll;
        logic [PULSE_W-1:0]      throttle;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_YAW,
        BK_PITCH,
        BK_ROLL,
        BK_FINISH
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/qxm_front.sv */
// Front end: accepts a request and forms the three rate errors.
// Depends on qxm_pkg; feeds qxm_queue.
`default_nettype none

module qxm_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [qxm_pkg::ANGLE_W-1:0] pitch_angle,
    input  wire logic signed [qxm_pkg::ANGLE_W-1:0] roll_angle,
    input  wire logic signed [qxm_pkg::RATE_W-1:0]  yaw_rate,
    input  wire logic signed [qxm_pkg::RATE_W-1:0]  pitch_rate,
    input  wire logic signed [qxm_pkg::RATE_W-1:0]  roll_rate,
    input  wire logic [qxm_pkg::PULSE_W-1:0]        yaw_cmd,
    input  wire logic [qxm_pkg::PULSE_W-1:0]        pitch_pulse,
    input  wire logic [qxm_pkg::PULSE_W-1:0]        roll_pulse,
    input  wire logic [qxm_pkg::PULSE_W-1:0]        throttle_cmd,
    output qxm_pkg::item_t                        q_wdata,
    output logic                                  q_wr_en,
    input  wire logic                             q_full
);
    import qxm_pkg::*;

    // Dead band on the stick pulse, scaled, minus fifteen times the angle.
    function automatic logic signed [NUM_W-1:0] sp_num(
        input logic [PULSE_W-1:0]        pulse,
        input logic signed [ANGLE_W-1:0] angle
    );
        logic signed [DB_W-1:0]  p;
        logic signed [DB_W-1:0]  db;
        logic signed [NUM_W-1:0] lvl;
        p  = $signed({2'b00, pulse});
        db = '0;
        if (p > DB_W'(DEADBAND_HIGH))
            db = p - DB_W'(DEADBAND_HIGH);
        else if (p < DB_W'(DEADBAND_LOW))
            db = p - DB_W'(DEADBAND_LOW);
        lvl = NUM_W'(angle) * NUM_W'(LEVEL_GAIN);
        return (NUM_W'(db) <<< RATE_FRAC_BITS) - lvl;
    endfunction

    // Signed divide by three, truncating toward zero.
    function automatic logic signed [NUM_W-1:0] sp_div3(
        input logic signed [NUM_W-1:0] num
    );
        logic                    neg;
        logic [NUM_W-1:0]        mag_full;
        logic [DIV_K-1:0]        mag;
        logic [2*DIV_K:0]        prod;
        logic [DIV_K-1:0]        q;
        neg      = num[NUM_W-1];
        mag_full = neg ? NUM_W'(-num) : NUM_W'(num);
        mag      = mag_full[DIV_K-1:0];
        prod     = (2*DIV_K+1)'(mag) * (2*DIV_K+1)'(SP_RECIP);
        q        = prod[DIV_RW +: DIV_K];
        return neg ? -$signed(NUM_W'(q)) : $signed(NUM_W'(q));
    endfunction

    // Error saturated to the stored error range.
    function automatic logic signed [ERR_W-1:0] err_calc(
        input logic signed [RATE_W-1:0] rate,
        input logic signed [NUM_W-1:0]  num
    );
        logic signed [CALC_W-1:0] v;
        v = CALC_W'(rate) - CALC_W'(sp_div3(num));
        if (v > CALC_W'(ERR_MAX))
            return ERR_W'(ERR_MAX);
        else if (v < CALC_W'(ERR_MIN))
            return ERR_W'(ERR_MIN);
        return v[ERR_W-1:0];
    endfunction

    logic                      s1_valid_reg;
    logic signed [NUM_W-1:0]   num_yaw_reg;
    logic signed [NUM_W-1:0]   num_pitch_reg;
    logic signed [NUM_W-1:0]   num_roll_reg;
    logic signed [RATE_W-1:0]  rate_yaw_reg;
    logic signed [RATE_W-1:0]  rate_pitch_reg;
    logic signed [RATE_W-1:0]  rate_roll_reg;
    logic [PULSE_W-1:0]        thr_reg;

    // The stage drains into the queue whenever the queue has room.
    assign in_ready = !s1_valid_reg || !q_full;
    assign q_wr_en  = s1_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Stage one: set point numerators and the captured rates.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            if ({1'b0, throttle_cmd} > 13'(YAW_ARM_THROTTLE))
                num_yaw_reg <= sp_num(yaw_cmd, '0);
            else
                num_yaw_reg <= '0;
            num_pitch_reg  <= sp_num(pitch_pulse, pitch_angle);
            num_roll_reg   <= sp_num(roll_pulse, roll_angle);
            rate_yaw_reg   <= yaw_rate;
            rate_pitch_reg <= pitch_rate;
            rate_roll_reg  <= roll_rate;
            thr_reg        <= throttle_cmd;
        end
    end

    // Stage two: divide and subtract on the way into the queue.
    always_comb
    begin
        q_wdata.err_yaw   = err_calc(rate_yaw_reg, num_yaw_reg);
        q_wdata.err_pitch = err_calc(rate_pitch_reg, num_pitch_reg);
        q_wdata.err_roll  = err_calc(rate_roll_reg, num_roll_reg);
        q_wdata.throttle  = thr_reg;
    end

endmodule

`default_nettype wire

/* rtl/qxm_queue.sv */
// Two-entry queue of classified requests between front and back.
// Depends on qxm_pkg for the entry type.
`default_nettype none

module qxm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire qxm_pkg::item_t  wdata,
    output logic                 full,
    input  wire logic            rd_en,
    output qxm_pkg::item_t       rdata,
    output logic                 empty
);
    import qxm_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 2'd1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

/* rtl/qxm_back.sv */
// Back end: per-axis PID on a shared multiplier set, then the X mixer.
// Depends on qxm_pkg; drains qxm_queue and drives the result channel.
`default_nettype none

module qxm_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire qxm_pkg::cfg_t             cfg,
    input  wire qxm_pkg::item_t            q_rdata,
    input  wire logic                      q_empty,
    output logic                           q_rd_en,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [qxm_pkg::PULSE_W-1:0]    motor_a,
    output logic [qxm_pkg::PULSE_W-1:0]    motor_b,
    output logic [qxm_pkg::PULSE_W-1:0]    motor_c,
    output logic [qxm_pkg::PULSE_W-1:0]    motor_d
);
    import qxm_pkg::*;

    back_state_t state_reg, state_next;

    logic signed [SUM_W-1:0] sum_reg  [3];
    logic signed [ERR_W-1:0] last_reg [3];
    logic signed [ERR_W-1:0] w_err_reg [3];
    logic [PULSE_W-1:0]      w_thr_reg;

    logic signed [ERR_W+GAIN_W:0]   prod_p_reg;
    logic signed [SUM_W+GAIN_W:0]   prod_i_reg;
    logic signed [ERR_W+GAIN_W+1:0] prod_d_reg;

    logic signed [PID_W-1:0] pid_yaw_reg;
    logic signed [PID_W-1:0] pid_pitch_reg;

    logic                    mix_valid_reg;
    logic signed [PID_W-1:0] mix_pid_reg [3];
    logic [PULSE_W-1:0]      mix_thr_reg;

    logic                    out_valid_reg;
    logic [PULSE_W-1:0]      motor_reg [4];

    logic                    mul_en;
    logic [1:0]              ax;
    logic                    load_work;
    logic                    load_mix;
    logic                    mix_fire;

    logic signed [ERR_W-1:0]   err_cur;
    logic signed [ERR_W:0]     delta;
    logic signed [SUM_W+2:0]   sum_raw;
    logic signed [SUM_W+2:0]   ilim;
    logic signed [SUM_W-1:0]   sum_new;
    logic [GAIN_W-1:0]         g_p;
    logic [GAIN_W-1:0]         g_i;
    logic [GAIN_W-1:0]         g_d;

    logic signed [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]          acc_mag;
    logic [ACC_W-1:0]          rnd;
    logic [9:0]                pid_mag;
    logic signed [PID_W-1:0]   pid_val;

    logic signed [MOT_W-1:0]   thr_s;
    logic signed [MOT_W-1:0]   p0;
    logic signed [MOT_W-1:0]   p1;
    logic signed [MOT_W-1:0]   p2;
    logic signed [MOT_W-1:0]   mix_raw [4];
    logic [PULSE_W-1:0]        mix_out [4];

    assign mix_fire = mix_valid_reg && (!out_valid_reg || out_ready);

    // Sequencer: one axis per cycle, the last accumulate overlaps the next pop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_rd_en    = 1'b0;
        load_work  = 1'b0;
        load_mix   = 1'b0;
        mul_en     = 1'b0;
        ax         = 2'd0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd_en    = 1'b1;
                    load_work  = 1'b1;
                    state_next = BK_YAW;
                end
            end
            BK_YAW:
            begin
                mul_en     = 1'b1;
                ax         = 2'd0;
                state_next = BK_PITCH;
            end
            BK_PITCH:
            begin
                mul_en     = 1'b1;
                ax         = 2'd1;
                state_next = BK_ROLL;
            end
            BK_ROLL:
            begin
                mul_en     = 1'b1;
                ax         = 2'd2;
                state_next = BK_FINISH;
            end
            BK_FINISH:
            begin
                if (!mix_valid_reg || mix_fire)
                begin
                    load_mix = 1'b1;
                    if (!q_empty)
                    begin
                        q_rd_en    = 1'b1;
                        load_work  = 1'b1;
                        state_next = BK_YAW;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Error sum update, derivative and gain selection for the current axis.
    always_comb
    begin
        err_cur = w_err_reg[ax];
        delta   = (ERR_W+1)'(err_cur) - (ERR_W+1)'(last_reg[ax]);
        sum_raw = (SUM_W+3)'(sum_reg[ax]) + (SUM_W+3)'(err_cur);
        ilim    = $signed((SUM_W+3)'(cfg.integral_limit));
        if (sum_raw > ilim)
            sum_new = ilim[SUM_W-1:0];
        else if (sum_raw < -ilim)
            sum_new = SUM_W'(-ilim);
        else
            sum_new = sum_raw[SUM_W-1:0];
        g_p = cfg.kp[GAIN_W*ax +: GAIN_W];
        g_i = cfg.ki[GAIN_W*ax +: GAIN_W];
        g_d = cfg.kd[GAIN_W*ax +: GAIN_W];
    end

    // Accumulate the registered products, round half away from zero, clamp.
    always_comb
    begin
        acc     = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg);
        acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        rnd     = (acc_mag + (ACC_W'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
        if (rnd > ACC_W'(cfg.pid_limit))
            pid_mag = cfg.pid_limit;
        else
            pid_mag = rnd[9:0];
        pid_val = acc[ACC_W-1] ? -$signed(PID_W'(pid_mag)) : $signed(PID_W'(pid_mag));
    end

    // Axis state, products and the per-item working copy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end
        else if (mul_en)
        begin
            sum_reg[ax]  <= sum_new;
            last_reg[ax] <= err_cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_work)
        begin
            w_err_reg[0] <= q_rdata.err_yaw;
            w_err_reg[1] <= q_rdata.err_pitch;
            w_err_reg[2] <= q_rdata.err_roll;
            w_thr_reg    <= q_rdata.throttle;
        end
        if (mul_en)
        begin
            prod_p_reg <= err_cur * $signed({1'b0, g_p});
            prod_i_reg <= sum_new * $signed({1'b0, g_i});
            prod_d_reg <= delta * $signed({1'b0, g_d});
        end
        if (state_reg == BK_PITCH)
            pid_yaw_reg <= pid_val;
        if (state_reg == BK_ROLL)
            pid_pitch_reg <= pid_val;
        if (load_mix)
        begin
            mix_pid_reg[0] <= pid_yaw_reg;
            mix_pid_reg[1] <= pid_pitch_reg;
            mix_pid_reg[2] <= pid_val;
            mix_thr_reg    <= w_thr_reg;
        end
        if (mix_fire)
        begin
            for (int k = 0; k < 4; k++)
                motor_reg[k] <= mix_out[k];
        end
    end

    // Mixer and output handshake flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_mix)
                mix_valid_reg <= 1'b1;
            else if (mix_fire)
                mix_valid_reg <= 1'b0;
            if (mix_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // X-frame mix, idle bypass, then motor bounds.
    always_comb
    begin
        thr_s = $signed(MOT_W'(mix_thr_reg));
        p0    = MOT_W'(mix_pid_reg[0]);
        p1    = MOT_W'(mix_pid_reg[1]);
        p2    = MOT_W'(mix_pid_reg[2]);
        if (mix_thr_reg >= cfg.throttle_idle)
        begin
            mix_raw[0] = thr_s - p2 - p1 + p0;
            mix_raw[1] = thr_s + p2 - p1 - p0;
            mix_raw[2] = thr_s - p2 + p1 - p0;
            mix_raw[3] = thr_s + p2 + p1 + p0;
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                mix_raw[k] = thr_s;
        end
        for (int k = 0; k < 4; k++)
        begin
            if (mix_raw[k] > $signed(MOT_W'(cfg.motor_max)))
                mix_out[k] = cfg.motor_max;
            else if (mix_raw[k] < $signed(MOT_W'(cfg.motor_min)))
                mix_out[k] = cfg.motor_min;
            else
                mix_out[k] = mix_raw[k][PULSE_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign motor_a   = motor_reg[0];
    assign motor_b   = motor_reg[1];
    assign motor_c   = motor_reg[2];
    assign motor_d   = motor_reg[3];

endmodule

`default_nettype wire

/* rtl/quad_x_pid_mixer.sv */
// Top level of the quad X PID mixer: configuration registers and the
// front, queue and back instances. Depends on qxm_pkg and all qxm_ modules.
//
// Usage: one request on the input channel (in_valid/in_ready) carries the
// angles, the filtered rates and the four receiver pulses of one control
// step; one result on the output channel (out_valid/out_ready) carries the
// four motor pulses. Configuration is written through cfg_wr_en, cfg_index
// and cfg_data while the block is idle; indexes follow the register list.
// The back end's shared multiplier set handles one axis per cycle, then
// accumulates the last axis while it pops the next waiting request; that
// step waits while the mix stage is held. The front end takes a request per
// cycle while the queue has room, into a two-entry queue, so requests are
// accepted while a result waits. Reset clears the error sums and last
// errors to zero and loads every configuration register with its default.
// When the receiver stalls, the result holds in the output register, one
// more sits in the mix stage, and the queue fills before in_ready drops.
`default_nettype none

module quad_x_pid_mixer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [2:0]                         cfg_index,
    input  wire logic [qxm_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [qxm_pkg::ANGLE_W-1:0] pitch_angle,
    input  wire logic signed [qxm_pkg::ANGLE_W-1:0] roll_angle,
    input  wire logic signed [qxm_pkg::RATE_W-1:0]  yaw_rate,
    input  wire logic signed [qxm_pkg::RATE_W-1:0]  pitch_rate,
    input  wire logic signed [qxm_pkg::RATE_W-1:0]  roll_rate,
    input  wire logic [qxm_pkg::PULSE_W-1:0]        yaw_cmd,
    input  wire logic [qxm_pkg::PULSE_W-1:0]        pitch_pulse,
    input  wire logic [qxm_pkg::PULSE_W-1:0]        roll_pulse,
    input  wire logic [qxm_pkg::PULSE_W-1:0]        throttle_cmd,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [qxm_pkg::PULSE_W-1:0]             motor_a,
    output logic [qxm_pkg::PULSE_W-1:0]             motor_b,
    output logic [qxm_pkg::PULSE_W-1:0]             motor_c,
    output logic [qxm_pkg::PULSE_W-1:0]             motor_d
);
    import qxm_pkg::*;

    cfg_t   cfg_reg;
    item_t  q_wdata;
    item_t  q_rdata;
    logic   q_wr_en;
    logic   q_rd_en;
    logic   q_full;
    logic   q_empty;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp             <= 48'd768;
            cfg_reg.ki             <= 48'd51;
            cfg_reg.kd             <= 48'd2199056809984;
            cfg_reg.pid_limit      <= 10'd400;
            cfg_reg.integral_limit <= 19'd512000;
            cfg_reg.throttle_idle  <= 12'd1012;
            cfg_reg.motor_min      <= 12'd1100;
            cfg_reg.motor_max      <= 12'd2000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KP:        cfg_reg.kp             <= cfg_data;
                CFG_KI:        cfg_reg.ki             <= cfg_data;
                CFG_KD:        cfg_reg.kd             <= cfg_data;
                CFG_PID_LIMIT: cfg_reg.pid_limit      <= cfg_data[9:0];
                CFG_INT_LIMIT: cfg_reg.integral_limit <= cfg_data[18:0];
                CFG_THR_IDLE:  cfg_reg.throttle_idle  <= cfg_data[PULSE_W-1:0];
                CFG_MOTOR_MIN: cfg_reg.motor_min      <= cfg_data[PULSE_W-1:0];
                CFG_MOTOR_MAX: cfg_reg.motor_max      <= cfg_data[PULSE_W-1:0];
                default:       cfg_reg.kp             <= cfg_reg.kp;
            endcase
        end
    end

    // Front end: set points and errors.
    qxm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pitch_angle    (pitch_angle),
        .roll_angle     (roll_angle),
        .yaw_rate       (yaw_rate),
        .pitch_rate     (pitch_rate),
        .roll_rate      (roll_rate),
        .yaw_cmd        (yaw_cmd),
        .pitch_pulse    (pitch_pulse),
        .roll_pulse     (roll_pulse),
        .throttle_cmd   (throttle_cmd),
        .q_wdata        (q_wdata),
        .q_wr_en        (q_wr_en),
        .q_full         (q_full)
    );

    // Queue between front and back.
    qxm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (q_wr_en),
        .wdata (q_wdata),
        .full  (q_full),
        .rd_en (q_rd_en),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back end: PID and mixer.
    qxm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_rdata   (q_rdata),
        .q_empty   (q_empty),
        .q_rd_en   (q_rd_en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .motor_a   (motor_a),
        .motor_b   (motor_b),
        .motor_c   (motor_c),
        .motor_d   (motor_d)
    );

endmodule

`default_nettype wire

/* dv/quad_x_pid_mixer_tb.sv */
// Self-checking testbench of the quad X PID mixer: directed table, then random control steps.
// Predicts motor pulses with its own PID and mixer model; depends on qxm_pkg and the RTL.
`default_nettype none

module quad_x_pid_mixer_tb;
    import qxm_pkg::*;

    typedef struct {
        logic signed [15:0] p_ang;
        logic signed [15:0] r_ang;
        logic signed [19:0] y_rate;
        logic signed [19:0] p_rate;
        logic signed [19:0] r_rate;
        logic [11:0] y_pulse;
        logic [11:0] p_pulse;
        logic [11:0] r_pulse;
        logic [11:0] thr;
    } step_t;

    typedef struct {
        logic [11:0] m[4];
        bit typed;
    } motors_t;

    typedef struct {
        step_t s;
        bit has_exp;
        logic [11:0] m[4];
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [2:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [19:0] yaw_rate;
    logic signed [19:0] pitch_rate;
    logic signed [19:0] roll_rate;
    logic [11:0] yaw_cmd;
    logic [11:0] pitch_pulse;
    logic [11:0] roll_pulse;
    logic [11:0] throttle_cmd;
    logic out_valid;
    logic out_ready;
    logic [11:0] motor_a;
    logic [11:0] motor_b;
    logic [11:0] motor_c;
    logic [11:0] motor_d;

    // Shadow copies of the registers and of the PID state.
    logic [47:0] kp_sh, ki_sh, kd_sh;
    longint pid_lim_sh, int_lim_sh, idle_sh, mmin_sh, mmax_sh;
    longint sum_sh[3];
    longint last_sh[3];

    motors_t motor_q[$];
    int errors;
    bit no_idle;

    quad_x_pid_mixer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pitch_angle(pitch_angle), .roll_angle(roll_angle),
        .yaw_rate(yaw_rate), .pitch_rate(pitch_rate), .roll_rate(roll_rate),
        .yaw_cmd(yaw_cmd), .pitch_pulse(pitch_pulse), .roll_pulse(roll_pulse),
        .throttle_cmd(throttle_cmd),
        .out_valid(out_valid), .out_ready(out_ready),
        .motor_a(motor_a), .motor_b(motor_b), .motor_c(motor_c), .motor_d(motor_d)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint lim(longint v, longint lo, longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint rate_target(longint angle, longint pulse);
        longint t;
        t = 0;
        if (pulse > longint'(DEADBAND_HIGH))
            t = pulse - longint'(DEADBAND_HIGH);
        else if (pulse < longint'(DEADBAND_LOW))
            t = pulse - longint'(DEADBAND_LOW);
        t = t * (longint'(1) << RATE_FRAC_BITS) - angle * longint'(LEVEL_GAIN);
        return t / longint'(3);
    endfunction

    // One control step: updates the shadow PID state and returns the motor pulses.
    function automatic motors_t mix_motors(step_t s);
        motors_t r;
        longint rate[3];
        longint tgt[3];
        longint pid[3];
        longint mv[4];
        longint err, dlt, acc, mag, thr;
        thr = longint'(s.thr);
        rate[0] = longint'(s.y_rate);
        rate[1] = longint'(s.p_rate);
        rate[2] = longint'(s.r_rate);
        tgt[0] = (thr > longint'(YAW_ARM_THROTTLE)) ?
                 rate_target(longint'(0), longint'(s.y_pulse)) : longint'(0);
        tgt[1] = rate_target(longint'(s.p_ang), longint'(s.p_pulse));
        tgt[2] = rate_target(longint'(s.r_ang), longint'(s.r_pulse));
        for (int a = 0; a < 3; a++)
        begin
            err = lim(rate[a] - tgt[a], longint'(ERR_MIN), longint'(ERR_MAX));
            dlt = err - last_sh[a];
            sum_sh[a] = lim(sum_sh[a] + err, -int_lim_sh, int_lim_sh);
            last_sh[a] = err;
            acc = err * longint'(kp_sh[16*a +: 16]) + sum_sh[a] * longint'(ki_sh[16*a +: 16])
                + dlt * longint'(kd_sh[16*a +: 16]);
            // Round to nearest with ties away from zero.
            mag = ((acc < 0 ? -acc : acc) + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
            pid[a] = lim(acc < 0 ? -mag : mag, -pid_lim_sh, pid_lim_sh);
        end
        for (int k = 0; k < 4; k++)
            mv[k] = thr;
        if (thr >= idle_sh)
        begin
            mv[0] = thr - pid[2] - pid[1] + pid[0];
            mv[1] = thr + pid[2] - pid[1] - pid[0];
            mv[2] = thr - pid[2] + pid[1] - pid[0];
            mv[3] = thr + pid[2] + pid[1] + pid[0];
        end
        // With inverted bounds the upper bound wins unless the value lies below both.
        for (int k = 0; k < 4; k++)
        begin
            if (mv[k] > mmax_sh)
                mv[k] = mmax_sh;
            else if (mv[k] < mmin_sh)
                mv[k] = mmin_sh;
            r.m[k] = mv[k][11:0];
        end
        r.typed = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic reset_shadow();
        kp_sh = 48'd768;
        ki_sh = 48'd51;
        kd_sh = 48'd2199056809984;
        pid_lim_sh = 400;
        int_lim_sh = 512000;
        idle_sh = 1012;
        mmin_sh = 1100;
        mmax_sh = 2000;
        for (int a = 0; a < 3; a++)
        begin
            sum_sh[a] = 0;
            last_sh[a] = 0;
        end
    endtask

    // Register write at a rising edge, applied to the shadow copy as well.
    // The caller drops the enable after its last write.
    task automatic write_reg(cfg_index_t idx, logic [47:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        case (idx)
            CFG_KP: kp_sh = val;
            CFG_KI: ki_sh = val;
            CFG_KD: kd_sh = val;
            CFG_PID_LIMIT: pid_lim_sh = longint'(val[9:0]);
            CFG_INT_LIMIT: int_lim_sh = longint'(val[18:0]);
            CFG_THR_IDLE: idle_sh = longint'(val[11:0]);
            CFG_MOTOR_MIN: mmin_sh = longint'(val[11:0]);
            CFG_MOTOR_MAX: mmax_sh = longint'(val[11:0]);
            default: ;
        endcase
    endtask

    // Present one request and hold it until accepted; queue its expectation.
    // Valid stays high afterwards until the next request or an explicit drop.
    task automatic send_step(step_t s, bit has_exp, logic [11:0] m0, logic [11:0] m1,
                             logic [11:0] m2, logic [11:0] m3);
        motors_t e;
        while (!no_idle && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        pitch_angle <= s.p_ang;
        roll_angle <= s.r_ang;
        yaw_rate <= s.y_rate;
        pitch_rate <= s.p_rate;
        roll_rate <= s.r_rate;
        yaw_cmd <= s.y_pulse;
        pitch_pulse <= s.p_pulse;
        roll_pulse <= s.r_pulse;
        throttle_cmd <= s.thr;
        in_valid <= 1'b1;
        e = mix_motors(s);
        if (has_exp)
        begin
            e.m[0] = m0;
            e.m[1] = m1;
            e.m[2] = m2;
            e.m[3] = m3;
            e.typed = 1'b1;
        end
        do
            @(posedge clk);
        while (!in_ready);
        motor_q.push_back(e);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (motor_q.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    function automatic step_t rand_step(bit shaped);
        step_t s;
        s.p_ang = 16'($urandom);
        s.r_ang = 16'($urandom);
        s.y_rate = 20'($urandom);
        s.p_rate = 20'($urandom);
        s.r_rate = 20'($urandom);
        s.y_pulse = 12'($urandom);
        s.p_pulse = 12'($urandom);
        s.r_pulse = 12'($urandom);
        s.thr = 12'($urandom);
        if (shaped)
        begin
            // Flight-like values keep the outputs away from the rails.
            s.p_ang = 16'(int'($urandom_range(2047)) - 1024);
            s.r_ang = 16'(int'($urandom_range(2047)) - 1024);
            s.y_rate = 20'(int'($urandom_range(8191)) - 4096);
            s.p_rate = 20'(int'($urandom_range(8191)) - 4096);
            s.r_rate = 20'(int'($urandom_range(8191)) - 4096);
            s.y_pulse = 12'($urandom_range(1560, 1440));
            s.p_pulse = 12'($urandom_range(1560, 1440));
            s.r_pulse = 12'($urandom_range(1560, 1440));
            s.thr = 12'($urandom_range(1800, 990));
        end
        return s;
    endfunction

    // Result side: random stall, compare each accepted result with the oldest expectation.
    initial
    begin
        motors_t e;
        logic [11:0] got[4];
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 8);
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got[0] = motor_a;
                got[1] = motor_b;
                got[2] = motor_c;
                got[3] = motor_d;
                if (motor_q.size() == 0)
                begin
                    report_mismatch("results pending", longint'(0), longint'(1));
                end
                else
                begin
                    e = motor_q.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (got[k] !== e.m[k])
                            report_mismatch($sformatf("motor %0d", k), longint'(got[k]),
                                            longint'(e.m[k]));
                end
            end
        end
    end

    // Directed table: extremes, idle throttle, dead band, error saturation.
    row_t dir_rows[$];

    function automatic step_t mk(longint pa, longint ra, longint yr, longint pr, longint rr,
                                 longint yp, longint pp, longint rp, longint th);
        step_t s;
        s.p_ang = 16'(pa);
        s.r_ang = 16'(ra);
        s.y_rate = 20'(yr);
        s.p_rate = 20'(pr);
        s.r_rate = 20'(rr);
        s.y_pulse = 12'(yp);
        s.p_pulse = 12'(pp);
        s.r_pulse = 12'(rp);
        s.thr = 12'(th);
        return s;
    endfunction

    task automatic add_row(step_t s, bit he, logic [11:0] v);
        row_t r;
        r.s = s;
        r.has_exp = he;
        for (int k = 0; k < 4; k++)
            r.m[k] = v;
        dir_rows.push_back(r);
    endtask

    initial
    begin
        step_t s;
        logic [47:0] v;
        errors = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_KP;
        cfg_data = '0;
        in_valid = 1'b0;
        pitch_angle = '0;
        roll_angle = '0;
        yaw_rate = '0;
        pitch_rate = '0;
        roll_rate = '0;
        yaw_cmd = '0;
        pitch_pulse = '0;
        roll_pulse = '0;
        throttle_cmd = '0;
        reset_shadow();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Centered sticks, level and still: no correction, idle, hover or full throttle; then extreme and edge inputs.
        add_row(mk(0, 0, 0, 0, 0, 1500, 1500, 1500, 0), 1, 12'd1100);
        add_row(mk(0, 0, 0, 0, 0, 1500, 1500, 1500, 1500), 1, 12'd1500);
        add_row(mk(0, 0, 0, 0, 0, 1500, 1500, 1500, 4095), 1, 12'd2000);
        add_row(mk(0, 0, 0, 0, 0, 1492, 1508, 1508, 1011), 1, 12'd1100);
        add_row(mk(32767, -32768, 524287, -524288, 524287, 4095, 0, 4095, 1500), 0, 0);
        add_row(mk(-32768, 32767, -524288, 524287, -524288, 0, 4095, 0, 1500), 0, 0);
        add_row(mk(-32768, -32768, -524288, -524288, -524288, 0, 0, 0, 1051), 0, 0);
        add_row(mk(32767, 32767, 524287, 524287, 524287, 4095, 4095, 4095, 1050), 0, 0);
        add_row(mk(0, 0, 1000, -1000, 500, 1491, 1509, 1507, 1012), 0, 0);
        add_row(mk(100, -100, 0, 0, 0, 1493, 1491, 1509, 1011), 0, 0);
        add_row(mk(0, 0, 0, 0, 0, 1500, 1500, 1500, 1600), 0, 0);
        foreach (dir_rows[i])
            send_step(dir_rows[i].s, dir_rows[i].has_exp, dir_rows[i].m[0], dir_rows[i].m[1],
                      dir_rows[i].m[2], dir_rows[i].m[3]);
        drain();

        // Register settings: zero gains, extremes, inverted bounds, per-axis gains, then random.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_KP, '0);
                    write_reg(CFG_KI, '0);
                    write_reg(CFG_KD, '0);
                    write_reg(CFG_PID_LIMIT, '0);
                    write_reg(CFG_INT_LIMIT, '0);
                    write_reg(CFG_THR_IDLE, '0);
                    write_reg(CFG_MOTOR_MIN, '0);
                    write_reg(CFG_MOTOR_MAX, '0);
                end
                1:
                begin
                    write_reg(CFG_KP, '1);
                    write_reg(CFG_KI, '1);
                    write_reg(CFG_KD, '1);
                    write_reg(CFG_PID_LIMIT, 48'h3FF);
                    write_reg(CFG_INT_LIMIT, 48'h7FFFF);
                    write_reg(CFG_THR_IDLE, 48'hFFF);
                    write_reg(CFG_MOTOR_MIN, '0);
                    write_reg(CFG_MOTOR_MAX, 48'hFFF);
                end
                2:
                begin
                    write_reg(CFG_THR_IDLE, 48'd0);
                    write_reg(CFG_MOTOR_MIN, 48'd1800);
                    write_reg(CFG_MOTOR_MAX, 48'd1200);
                end
                3:
                begin
                    write_reg(CFG_KP, 48'h0400_0300_0200);
                    write_reg(CFG_KI, 48'h0040_0033_0020);
                    write_reg(CFG_KD, 48'h0100_0200_0080);
                    write_reg(CFG_PID_LIMIT, 48'd400);
                    write_reg(CFG_INT_LIMIT, 48'd5000);
                    write_reg(CFG_THR_IDLE, 48'd1012);
                    write_reg(CFG_MOTOR_MIN, 48'd1100);
                    write_reg(CFG_MOTOR_MAX, 48'd2000);
                end
                default:
                begin
                    v = 48'({$urandom, $urandom});
                    write_reg(CFG_KP, v);
                    v = 48'({$urandom, $urandom});
                    write_reg(CFG_KI, v);
                    v = 48'({$urandom, $urandom});
                    write_reg(CFG_KD, v);
                    write_reg(CFG_PID_LIMIT, 48'($urandom));
                    write_reg(CFG_INT_LIMIT, 48'($urandom));
                    write_reg(CFG_THR_IDLE, 48'($urandom_range(1300, 900)));
                    write_reg(CFG_MOTOR_MIN, 48'($urandom_range(1200, 0)));
                    write_reg(CFG_MOTOR_MAX, 48'($urandom_range(4095, 1500)));
                end
            endcase
            cfg_wr_en <= 1'b0;
            // Phase 5 runs without random idles on either side.
            no_idle = (ph == 5);
            for (int i = 0; i < 180; i++)
            begin
                s = rand_step($urandom_range(3) != 0);
                send_step(s, 0, 0, 0, 0, 0);
                if (i == 90)
                begin
                    // Sender holds off until every pending result has come back.
                    in_valid <= 1'b0;
                    do
                        @(negedge clk);
                    while (motor_q.size() != 0);
                end
            end
            drain();
        end
        no_idle = 1'b0;

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/qxm_pkg.sv
rtl/qxm_front.sv
rtl/qxm_queue.sv
rtl/qxm_back.sv
rtl/quad_x_pid_mixer.sv
dv/quad_x_pid_mixer_tb.sv
